FILE: sv/ufca_pkg.sv
// shared types and constants for the union-find component-and core
package ufca_pkg;

  localparam int NODE_FIELD_W = 10;
  localparam int WEIGHT_FIELD_W = 16;
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [NODE_FIELD_W-1:0]   node_a;
    logic [NODE_FIELD_W-1:0]   node_b;
    logic [WEIGHT_FIELD_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                      connected;
    logic [WEIGHT_FIELD_W-1:0] walk_cost;
  } out_item_t;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic red1;
    logic red2;
    logic sel_b;
    logic root_b;
    logic cur_from_node;
    logic rd_par;
    logic cur_from_par;
    logic set_root;
    logic comp_wr;
    logic rd_attr;
    logic latch_a;
    logic merge;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind;
    logic par_self;
    logic cur_is_root;
    logic out_free;
  } status_t;

endpackage

FILE: sv/ufca_ram.sv
// generic single-write, single-read ram with registered read data
module ufca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/ufca_ctrl.sv
// sequencer for clearing, root walks, path compression, merge and query output
module ufca_ctrl
  import ufca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RED1,
    S_RED2,
    S_FIND,
    S_FCHK,
    S_COMP,
    S_CWR,
    S_ATTR_A,
    S_ATTR_B,
    S_MERGE,
    S_QOUT
  } state_t;

  state_t state, state_next;
  logic   side, side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd        = '0;
    cmd.sel_b  = side;
    cmd.root_b = side;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        side_next = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_RED1;
        end
      end
      S_RED1: begin
        cmd.red1 = 1'b1;
        state_next = S_RED2;
      end
      S_RED2: begin
        cmd.red2 = 1'b1;
        state_next = S_FIND;
      end
      S_FIND: begin
        cmd.rd_par = 1'b1;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (status.par_self) begin
          cmd.set_root = 1'b1;
          cmd.cur_from_node = 1'b1;
          state_next = S_COMP;
        end else begin
          cmd.cur_from_par = 1'b1;
          state_next = S_FIND;
        end
      end
      S_COMP: begin
        if (status.cur_is_root) begin
          if (!side) begin
            side_next = 1'b1;
            cmd.sel_b = 1'b1;
            cmd.cur_from_node = 1'b1;
            state_next = S_FIND;
          end else begin
            state_next = S_ATTR_A;
          end
        end else begin
          cmd.rd_par = 1'b1;
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.comp_wr = 1'b1;
        state_next = S_COMP;
      end
      S_ATTR_A: begin
        cmd.rd_attr = 1'b1;
        cmd.sel_b = 1'b0;
        state_next = (status.kind == KIND_QUERY) ? S_QOUT : S_ATTR_B;
      end
      S_ATTR_B: begin
        cmd.rd_attr = 1'b1;
        cmd.sel_b = 1'b1;
        cmd.latch_a = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_next = S_IDLE;
      end
      S_QOUT: begin
        if (status.out_free) begin
          cmd.load_res = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/ufca_dp.sv
// datapath: node tables, walk registers, merge logic and result register
module ufca_dp
  import ufca_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output status_t   status,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP = (1 << RECIP_SHIFT) / NODES;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [WEIGHT_BITS-1:0] ONES = {WEIGHT_BITS{1'b1}};

  in_item_t               in_q;
  logic [NODE_FIELD_W-1:0] qa, qb;
  logic [NW-1:0]           na, nb;
  logic [NW-1:0]           cur, ra, rb;
  logic [NW-1:0]           clr_idx;
  logic [RANK_W-1:0]       rank_a;
  logic [WEIGHT_BITS-1:0]  and_a;
  logic                    res_valid;
  out_item_t               res_q;

  logic [30:0]             prod_a, prod_b;
  logic [31:0]             rem_a, rem_b, mod_a, mod_b;
  logic [NW-1:0]           na_next, nb_next, root_sel, node_sel;

  logic [NW-1:0]           par_rd;
  logic [RANK_W-1:0]       rank_rd;
  logic [WEIGHT_BITS-1:0]  and_rd;

  logic                    par_we, rank_we, and_we;
  logic [NW-1:0]           par_waddr, par_wdata, rank_waddr, and_waddr, attr_raddr;
  logic [RANK_W-1:0]       rank_wdata;
  logic [WEIGHT_BITS-1:0]  and_wdata, wt, merged;
  logic [31:0]             w32, cost32;
  logic                    diff_root;

  // node index reduction by reciprocal multiply and one correction
  assign prod_a = 31'(in_q.node_a) * 31'(RECIP);
  assign prod_b = 31'(in_q.node_b) * 31'(RECIP);
  assign rem_a  = 32'(in_q.node_a) - 32'(qa) * 32'(NODES);
  assign rem_b  = 32'(in_q.node_b) - 32'(qb) * 32'(NODES);
  assign mod_a  = (rem_a >= 32'(NODES)) ? rem_a - 32'(NODES) : rem_a;
  assign mod_b  = (rem_b >= 32'(NODES)) ? rem_b - 32'(NODES) : rem_b;
  assign na_next = mod_a[NW-1:0];
  assign nb_next = mod_b[NW-1:0];

  assign root_sel = cmd.root_b ? rb : ra;
  assign node_sel = cmd.sel_b ? nb : na;
  assign attr_raddr = cmd.sel_b ? rb : ra;

  assign w32 = 32'(in_q.edge_weight);
  assign wt  = w32[WEIGHT_BITS-1:0];
  assign merged = and_a & and_rd & wt;
  assign diff_root = (ra != rb);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_q <= in_data;
    end
    if (cmd.red1) begin
      qa <= prod_a[RECIP_SHIFT +: NODE_FIELD_W];
      qb <= prod_b[RECIP_SHIFT +: NODE_FIELD_W];
    end
    if (cmd.red2) begin
      na  <= na_next;
      nb  <= nb_next;
      cur <= na_next;
    end else if (cmd.cur_from_node) begin
      cur <= node_sel;
    end else if (cmd.cur_from_par || cmd.comp_wr) begin
      cur <= par_rd;
    end
    if (cmd.set_root) begin
      if (cmd.sel_b) begin
        rb <= cur;
      end else begin
        ra <= cur;
      end
    end
    if (cmd.latch_a) begin
      rank_a <= rank_rd;
      and_a  <= and_rd;
    end
    if (cmd.load_res) begin
      res_q.connected <= !diff_root;
      res_q.walk_cost <= diff_root ? '0 : cost32[WEIGHT_FIELD_W-1:0];
    end
  end

  assign cost32 = 32'(and_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.load_res) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // table write selection
  always_comb begin
    par_we     = 1'b0;
    par_waddr  = cur;
    par_wdata  = root_sel;
    rank_we    = 1'b0;
    rank_waddr = ra;
    rank_wdata = rank_a + 1'b1;
    and_we     = 1'b0;
    and_waddr  = ra;
    and_wdata  = merged;
    priority if (cmd.clr_wr) begin
      par_we     = 1'b1;
      par_waddr  = clr_idx;
      par_wdata  = clr_idx;
      rank_we    = 1'b1;
      rank_waddr = clr_idx;
      rank_wdata = '0;
      and_we     = 1'b1;
      and_waddr  = clr_idx;
      and_wdata  = ONES;
    end else if (cmd.comp_wr) begin
      par_we = 1'b1;
    end else if (cmd.merge) begin
      and_we = 1'b1;
      if (diff_root) begin
        par_we = 1'b1;
        priority if (rank_a > rank_rd) begin
          par_waddr = rb;
          par_wdata = ra;
        end else if (rank_a < rank_rd) begin
          par_waddr = ra;
          par_wdata = rb;
          and_waddr = rb;
        end else begin
          par_waddr = rb;
          par_wdata = ra;
          rank_we   = (rank_a < RANK_MAX);
        end
      end
    end
  end

  ufca_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link_ram (
    .clk     (clk),
    .wr_en   (par_we),
    .wr_addr (par_waddr),
    .wr_data (par_wdata),
    .rd_en   (cmd.rd_par),
    .rd_addr (cur),
    .rd_data (par_rd)
  );

  ufca_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rank (
    .clk     (clk),
    .wr_en   (rank_we),
    .wr_addr (rank_waddr),
    .wr_data (rank_wdata),
    .rd_en   (cmd.rd_attr),
    .rd_addr (attr_raddr),
    .rd_data (rank_rd)
  );

  ufca_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(NODES)) u_and (
    .clk     (clk),
    .wr_en   (and_we),
    .wr_addr (and_waddr),
    .wr_data (and_wdata),
    .rd_en   (cmd.rd_attr),
    .rd_addr (attr_raddr),
    .rd_data (and_rd)
  );

  assign status.clr_last    = (clr_idx == LAST_NODE);
  assign status.kind        = in_q.kind;
  assign status.par_self    = (par_rd == cur);
  assign status.cur_is_root = (cur == root_sel);
  assign status.out_free    = !res_valid || out_ready;

  assign out_valid = res_valid;
  assign out_data  = res_q;

endmodule

FILE: sv/union_find_component_and_core.sv
// top level of the union-find table with per-component weight and
// an item walks to both roots and relinks the nodes on the way; a
// query also waits for the result register to drain if it is still full
// the parent table takes one read per root walk step and one read and one write per node relinked
// after reset a clearing pass over every node initializes all three tables,
// during which no input transfer is taken
module union_find_component_and_core
  import ufca_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  ufca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ufca_dp #(.NODES(NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/testbench.sv
// testbench for the union-find component-and core: forest predictor and result checks
`timescale 1ns / 100ps

module testbench;
  import ufca_pkg::*;

  localparam int NODE_COUNT = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 600;
  localparam int END_WAIT = 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  logic [NODE_FIELD_W-1:0] link_tab [NODE_COUNT];
  logic [RANK_W-1:0] rank_tab [NODE_COUNT];
  logic [WEIGHT_FIELD_W-1:0] and_tab [NODE_COUNT];
  out_item_t pending_answers [$];

  int mismatches = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit hold_active = 1'b0;

  union_find_component_and_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // root lookup with full path compression
  function automatic logic [NODE_FIELD_W-1:0] root_of(logic [NODE_FIELD_W-1:0] x);
    logic [NODE_FIELD_W-1:0] r, cur, nxt;
    r = x;
    while (link_tab[r] != r) r = link_tab[r];
    cur = x;
    while (cur != r) begin
      nxt = link_tab[cur];
      link_tab[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  task automatic apply_to_forest(input in_item_t it);
    logic [NODE_FIELD_W-1:0] ra, rb, keep;
    logic [WEIGHT_FIELD_W-1:0] merged;
    out_item_t res;
    ra = root_of(it.node_a);
    rb = root_of(it.node_b);
    if (it.kind == KIND_ADD) begin
      merged = and_tab[ra] & and_tab[rb] & it.edge_weight;
      keep = ra;
      if (ra != rb) begin
        if (rank_tab[ra] > rank_tab[rb]) begin
          link_tab[rb] = ra;
        end else if (rank_tab[ra] < rank_tab[rb]) begin
          link_tab[ra] = rb;
          keep = rb;
        end else begin
          link_tab[rb] = ra;
          if (rank_tab[ra] < RANK_MAX) rank_tab[ra] = rank_tab[ra] + 1'b1;
        end
      end
      and_tab[keep] = merged;
    end else begin
      res.connected = (ra == rb);
      res.walk_cost = (ra == rb) ? and_tab[ra] : '0;
      pending_answers = {pending_answers, res};
    end
  endtask

  always @(posedge clk) begin : answer_check
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer, expected none, actual %0d/%h", $time,
                 out_data.connected, out_data.walk_cost);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data.connected !== want.connected) begin
          $display("%0t: connected expected %0d actual %0d", $time, want.connected,
                   out_data.connected);
          mismatches++;
        end
        if (out_data.walk_cost !== want.walk_cost) begin
          $display("%0t: walk_cost expected %h actual %h", $time, want.walk_cost,
                   out_data.walk_cost);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 19) < 8) return 0;
    return gap_len();
  endfunction

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
        repeat (50) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  function automatic in_item_t make_item(logic kind, logic [NODE_FIELD_W-1:0] a,
                                         logic [NODE_FIELD_W-1:0] b,
                                         logic [WEIGHT_FIELD_W-1:0] w);
    in_item_t it;
    it.kind = kind;
    it.node_a = a;
    it.node_b = b;
    it.edge_weight = w;
    return it;
  endfunction

  function automatic logic [WEIGHT_FIELD_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9) return '1;
    if (r < 16) return ~(16'h1 << $urandom_range(0, 15));
    if (r < 18) return WEIGHT_FIELD_W'($urandom_range(0, 65535));
    if (r == 18) return '0;
    return ~(16'($urandom) & 16'($urandom) & 16'($urandom));
  endfunction

  function automatic in_item_t random_item(logic [NODE_FIELD_W-1:0] base, int unsigned span);
    in_item_t it;
    int unsigned r;
    it.kind = ($urandom_range(0, 9) < 5) ? KIND_QUERY : KIND_ADD;
    it.node_a = base + NODE_FIELD_W'($urandom_range(0, span - 1));
    it.node_b = base + NODE_FIELD_W'($urandom_range(0, span - 1));
    it.edge_weight = pick_weight();
    r = $urandom_range(0, 19);
    if (r == 0) it.node_a = NODE_FIELD_W'($urandom_range(0, NODE_COUNT - 1));
    else if (r == 1) it.node_b = NODE_FIELD_W'($urandom_range(0, NODE_COUNT - 1));
    else if (r == 2) it.node_b = it.node_a;
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_to_forest(it);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic test_fresh_nodes();
    send_item(make_item(KIND_QUERY, 10'd0, 10'd0, 16'h0000), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd1023, 10'd1023, 16'hFFFF), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd0, 10'd1023, 16'h1234), pick_gap());
  endtask

  task automatic test_rank_joins();
    send_item(make_item(KIND_ADD, 10'd0, 10'd1023, 16'hFFFF), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd1023, 10'd0, 16'h0000), pick_gap());
    send_item(make_item(KIND_ADD, 10'd2, 10'd3, 16'hF0FF), pick_gap());
    send_item(make_item(KIND_ADD, 10'd1023, 10'd2, 16'hFFFE), pick_gap());
    send_item(make_item(KIND_ADD, 10'd4, 10'd3, 16'hFFFF), pick_gap());
    send_item(make_item(KIND_ADD, 10'd5, 10'd6, 16'hFFFF), pick_gap());
    send_item(make_item(KIND_ADD, 10'd7, 10'd5, 16'h7FFF), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd3, 10'd4, 16'hFFFF), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd6, 10'd7, 16'h0000), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd4, 10'd6, 16'h0000), pick_gap());
  endtask

  task automatic test_repeat_edges();
    send_item(make_item(KIND_ADD, 10'd8, 10'd8, 16'h0F0F), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd8, 10'd8, 16'h0000), pick_gap());
    send_item(make_item(KIND_ADD, 10'd3, 10'd1023, 16'hAAAA), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd0, 10'd4, 16'h0000), pick_gap());
    send_item(make_item(KIND_ADD, 10'd6, 10'd5, 16'h0000), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd7, 10'd6, 16'hFFFF), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd8, 10'd9, 16'h0000), pick_gap());
    send_item(make_item(KIND_ADD, 10'd512, 10'd511, 16'h5555), pick_gap());
    send_item(make_item(KIND_QUERY, 10'd511, 10'd512, 16'h0000), pick_gap());
  endtask

  task automatic test_backpressure();
    logic [NODE_FIELD_W-1:0] base;
    base = NODE_FIELD_W'($urandom_range(0, NODE_COUNT - 1));
    release_input();
    long_hold = 1'b1;
    while (!hold_active) @(posedge clk);
    repeat (60) send_item(random_item(base, 16), 0);
  endtask

  task automatic test_drain_pause();
    logic [NODE_FIELD_W-1:0] base;
    base = NODE_FIELD_W'($urandom_range(0, NODE_COUNT - 1));
    repeat (12) send_item(random_item(base, 12), pick_gap());
    release_input();
    do @(posedge clk); while (pending_answers.size() != 0);
    repeat (12) send_item(random_item(base, 12), pick_gap());
  endtask

  task automatic test_random_traffic(input int unsigned total);
    int unsigned sent, span, burst;
    logic [NODE_FIELD_W-1:0] base;
    sent = 0;
    while (sent < total) begin
      base = NODE_FIELD_W'($urandom_range(0, NODE_COUNT - 1));
      span = $urandom_range(4, 40);
      burst = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 7) == 0);
      repeat (burst) begin
        send_item(random_item(base, span), pick_gap());
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NODE_COUNT; i++) begin
      link_tab[i] = NODE_FIELD_W'(i);
      rank_tab[i] = '0;
      and_tab[i] = '1;
    end
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_fresh_nodes();
    test_rank_joins();
    test_repeat_edges();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(1600);
    release_input();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
